### hdl/byte_set_statistics_and_sort_unit_defines.svh
`ifndef BYTE_SET_STATISTICS_AND_SORT_UNIT_DEFINES_SVH
`define BYTE_SET_STATISTICS_AND_SORT_UNIT_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define BSSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsss assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define BSSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsss assertion failed");

`endif

### hdl/bsss_pkg.sv
`default_nettype none

package bsss_pkg;

  // command for every cell of the sorting row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT,
    CMD_CLEAR
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e  cmd;
    logic [7:0] new_value;
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_STAT,
    ST_ELEM
  } seq_state_e;

  localparam logic [7:0] BYTE_MAX  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic KIND_STAT = 1'b0;
  localparam logic KIND_ELEM = 1'b1;

endpackage

`default_nettype wire

### hdl/bsss_cell.sv
`default_nettype none

module bsss_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bsss_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]           left_val_i,
  input  wire logic                 left_vld_i,
  input  wire logic [7:0]           right_val_i,
  input  wire logic                 right_vld_i,
  output logic [7:0]                val_o,
  output logic                      vld_o
);
  import bsss_pkg::*;

  logic [7:0] val_q, val_d;
  logic       vld_q, vld_d;
  logic       take_left, take_new;

  // insertion: larger values push the row to the right
  assign take_left = left_vld_i && (ctrl_i.new_value > left_val_i);
  assign take_new  = left_vld_i && !take_left && (!vld_q || (ctrl_i.new_value > val_q));

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (take_left) begin
          val_d = left_val_i;
          vld_d = 1'b1;
        end else if (take_new) begin
          val_d = ctrl_i.new_value;
          vld_d = 1'b1;
        end
      end
      CMD_SHIFT: begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
      CMD_CLEAR: begin
        vld_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

### hdl/bsss_div.sv
`default_nettype none

module bsss_div #(
  parameter int unsigned SW = 14,
  parameter int unsigned CW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [SW-1:0] dividend_i,
  input  wire logic [CW-1:0] divisor_i,
  output logic [SW-1:0]      quot_o,
  output logic               done_o
);
  import bsss_pkg::*;

  localparam int unsigned NW = $clog2(SW + 1);

  logic [CW-1:0] rem_q, rem_d;
  logic [SW-1:0] quo_q, quo_d;
  logic [CW-1:0] div_q;
  logic [NW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [CW:0]   trial, diff;
  logic          ge;

  // one quotient bit per cycle, restoring form
  assign trial = {rem_q, quo_q[SW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};
  assign rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
  assign quo_d = {quo_q[SW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == NW'(SW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### hdl/byte_set_statistics_and_sort_unit.sv
// Byte set statistics and sort unit.
// Input channel (in_valid_i / in_stall_o): one byte per transfer, last_item_i on the
// final byte of a set. Bytes load at one per cycle into a row of sorting cells; bytes
// past MAX_ITEMS are discarded and reported in the dropped field.
// After the marked byte the input stalls while the row rotates once through its
// MAX_ITEMS cells to pick up the median and a single divider forms the mean;
// the statistics record follows once both are done.
// Output channel (out_valid_o / out_stall_i): one statistics record, then, when
// emit_sorted is 1, one record per kept byte, largest first, one per cycle when
// not stalled. last_of_run_o marks the final record of the set.
// While the receiver stalls the current record holds; the input stays stalled
// until the final record is taken, then the set is cleared and loading resumes.
// Configuration: cfg_we_i writes cfg_wdata_i into emit_sorted (reset value 1);
// write only while idle.
// Reset clears the set and the cell valid bits; no clearing pass is needed.
`default_nettype none

module byte_set_statistics_and_sort_unit #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] value_i,
  input  wire logic       last_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            record_kind_o,
  output logic [7:0]      mean_value_o,
  output logic [7:0]      median_value_o,
  output logic [7:0]      largest_o,
  output logic [7:0]      smallest_o,
  output logic [7:0]      element_o,
  output logic [5:0]      item_count_o,
  output logic            dropped_o,
  output logic            last_of_run_o
);
  import bsss_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 8 + CW;

  seq_state_e    state_q, state_d;
  logic          emit_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [7:0]    max_q, max_d, min_q, min_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rot_q;
  logic [CW-1:0] idx_q;
  logic [7:0]    mid_lo_q, mid_hi_q;
  logic [7:0]    mean_q, med_q;
  logic [8:0]    mid_sum;
  logic          in_xfer, out_xfer, full, rot_run, last_rec, clear_set;
  logic          div_start, div_done;
  logic [SW-1:0] quot;
  logic [CW-1:0] half;
  cell_ctrl_t    ctrl;
  cell_cmd_e     cmd;

  logic [7:0] cell_val [MAX_ITEMS];
  logic       cell_vld [MAX_ITEMS];

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign full      = (cnt_q == CW'(MAX_ITEMS));
  assign rot_run   = (state_q == ST_CALC) && (rot_q != CW'(MAX_ITEMS));
  assign half      = cnt_q >> 1;
  assign last_rec  = (state_q == ST_STAT) ? !emit_q : (idx_q == (cnt_q - 1'b1));
  assign clear_set = out_xfer && last_rec;
  assign div_start = in_xfer && last_item_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_xfer && last_item_i) state_d = ST_CALC;
      ST_CALC: if (!rot_run && div_done) state_d = ST_STAT;
      ST_STAT: if (out_xfer) state_d = emit_q ? ST_ELEM : ST_LOAD;
      ST_ELEM: if (clear_set) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // handshake and cell commands
  always_comb begin
    in_stall_o  = (state_q != ST_LOAD);
    out_valid_o = (state_q == ST_STAT) || (state_q == ST_ELEM);
    cmd         = CMD_HOLD;
    if (in_xfer && !full) begin
      cmd = CMD_INSERT;
    end else if (rot_run || (state_q == ST_ELEM && out_xfer && !last_rec)) begin
      cmd = CMD_SHIFT;
    end else if (clear_set) begin
      cmd = CMD_CLEAR;
    end
  end

  assign ctrl.cmd       = cmd;
  assign ctrl.new_value = value_i;

  // running statistics of the loaded bytes
  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    ovf_d = ovf_q;
    if (in_xfer) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + SW'(value_i);
        if (value_i > max_q) max_d = value_i;
        if (value_i < min_q) min_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      emit_q  <= 1'b1;
      cnt_q   <= '0;
      sum_q   <= '0;
      max_q   <= BYTE_ZERO;
      min_q   <= BYTE_MAX;
      ovf_q   <= 1'b0;
      rot_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) emit_q <= cfg_wdata_i;
      if (clear_set) begin
        cnt_q <= '0;
        sum_q <= '0;
        max_q <= BYTE_ZERO;
        min_q <= BYTE_MAX;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        max_q <= max_d;
        min_q <= min_d;
        ovf_q <= ovf_d;
      end
      if (div_start) begin
        rot_q <= '0;
      end else if (rot_run) begin
        rot_q <= rot_q + 1'b1;
      end
      if (state_q == ST_STAT) begin
        idx_q <= '0;
      end else if (state_q == ST_ELEM && out_xfer) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // median taps as the rotation passes the head cell
  assign mid_sum = {1'b0, mid_lo_q} + {1'b0, mid_hi_q};

  always_ff @(posedge clk_i) begin
    if (rot_run && (rot_q + 1'b1) == half) mid_lo_q <= cell_val[0];
    if (rot_run && rot_q == half) mid_hi_q <= cell_val[0];
    if (state_q == ST_CALC) begin
      mean_q <= quot[7:0];
      med_q  <= cnt_q[0] ? mid_hi_q : mid_sum[8:1];
    end
  end

  bsss_div #(
    .SW(SW),
    .CW(CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // row of sorting cells, largest at the head; rotation wraps to the tail
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [7:0] lv, rv;
    logic       lvld, rvld;
    if (i == 0) begin : g_head
      assign lv   = BYTE_MAX;
      assign lvld = 1'b1;
    end else begin : g_body
      assign lv   = cell_val[i-1];
      assign lvld = cell_vld[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rv   = cell_val[0];
      assign rvld = rot_run ? cell_vld[0] : 1'b0;
    end else begin : g_next
      assign rv   = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end
    bsss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_val_i  (lv),
      .left_vld_i  (lvld),
      .right_val_i (rv),
      .right_vld_i (rvld),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i])
    );
  end

  // result fields
  assign record_kind_o  = (state_q == ST_ELEM) ? KIND_ELEM : KIND_STAT;
  assign mean_value_o   = mean_q;
  assign median_value_o = med_q;
  assign largest_o      = max_q;
  assign smallest_o     = min_q;
  assign element_o      = (state_q == ST_ELEM) ? cell_val[0] : BYTE_ZERO;
  assign item_count_o   = 6'(cnt_q);
  assign dropped_o      = ovf_q;
  assign last_of_run_o  = last_rec;

endmodule

`default_nettype wire

### hdl/bsss_checker.sv
`default_nettype none

`include "byte_set_statistics_and_sort_unit_defines.svh"

module bsss_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       record_kind_o,
  input wire logic [7:0] largest_o,
  input wire logic [7:0] smallest_o,
  input wire logic [7:0] element_o,
  input wire logic       last_of_run_o
);
  import bsss_pkg::*;

  // a stalled record stays offered
  `BSSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // no loading while results are being offered
  `BSSS_ASSERT_NOW(a_in_blocked, out_valid_o, in_stall_o)
  // the final record of a set closes the run
  `BSSS_ASSERT_NEXT(a_run_closes, out_valid_o && !out_stall_i && last_of_run_o, !out_valid_o)
  // sorted elements lie within the reported range
  `BSSS_ASSERT_NOW(a_elem_range, out_valid_o && record_kind_o == KIND_ELEM,
    element_o <= largest_o && element_o >= smallest_o)

endmodule

bind byte_set_statistics_and_sort_unit bsss_checker u_bsss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .record_kind_o (record_kind_o),
  .largest_o     (largest_o),
  .smallest_o    (smallest_o),
  .element_o     (element_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
